>>> rtl/fevd_pkg.sv
package fevd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 17;
    localparam int SUM_W      = 26;
    localparam int LEVEL_W    = 18;
    localparam int FRAMES_W   = 8;
    localparam int RATE_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_LEVEL       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_ATTACK_MARGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_FRAMES     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_FRAMES      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_DIVISOR       = 3'd4;

    localparam logic [LEVEL_W-1:0]  RST_ENERGY_LEVEL       = 18'd500;
    localparam logic [LEVEL_W-1:0]  RST_FAST_ATTACK_MARGIN = 18'd400;
    localparam logic [FRAMES_W-1:0] RST_RELEASE_FRAMES     = 8'd40;
    localparam logic [FRAMES_W-1:0] RST_ATTACK_FRAMES      = 8'd15;
    localparam logic [RATE_W-1:0]   RST_RATE_DIVISOR       = 4'd1;

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [LEVEL_W-1:0] SCORE_MAX = {LEVEL_W{1'b1}};

    localparam logic DIV_SEL_COUNT = 1'b0;
    localparam logic DIV_SEL_SUM   = 1'b1;

    typedef struct packed {
        logic acc;
        logic div_start;
        logic div_sel;
        logic denom_load;
        logic judge;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/fevd_if.sv
interface fevd_in_if;
    import fevd_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;
    modport source (output valid, output sample, output frame_end, input ready);
    modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface fevd_out_if;
    import fevd_pkg::*;
    logic               valid;
    logic               ready;
    logic               talking;
    logic [LEVEL_W-1:0] frame_score;
    modport source (output valid, output talking, output frame_score, input ready);
    modport sink   (input valid, input talking, input frame_score, output ready);
endinterface

interface fevd_cfg_if;
    import fevd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/fevd_div.sv
module fevd_div #(
    parameter int N_W = 26,
    parameter int D_W = 13
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic           o_busy,
    output logic           o_done,
    output logic [N_W-1:0] o_quotient
);

    localparam int STEP_W = (N_W > 1) ? $clog2(N_W) : 1;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [D_W-1:0]    r_rem;
    logic [D_W-1:0]    r_div;
    logic [N_W-1:0]    r_quo;
    logic [D_W:0]      w_shift;
    logic [D_W:0]      w_diff;
    logic              w_fit;

    assign w_shift = {r_rem, r_quo[N_W-1]};
    assign w_fit   = w_shift >= {1'b0, r_div};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[D_W-1:0] : w_shift[D_W-1:0];
            r_quo <= {r_quo[N_W-2:0], w_fit};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> rtl/fevd_datapath.sv
module fevd_datapath #(
    parameter int MAX_FRAME_SAMPLES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [fevd_pkg::SAMPLE_W-1:0] i_sample,
    input  fevd_pkg::t_dp_cmd                   i_cmd,
    output fevd_pkg::t_dp_sts                   o_sts,
    fevd_cfg_if.sink                            cfg,
    fevd_out_if.source                          out_ch
);
    import fevd_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int DEN_W = (CNT_W > RATE_W) ? CNT_W : RATE_W;

    logic [LEVEL_W-1:0]  r_level;
    logic [LEVEL_W-1:0]  r_margin;
    logic [FRAMES_W-1:0] r_rel_frames;
    logic [FRAMES_W-1:0] r_att_frames;
    logic [RATE_W-1:0]   r_rate;

    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_count;
    logic [DEN_W-1:0]    r_denom;
    logic [FRAMES_W-1:0] r_rel_hits, n_rel_hits;
    logic [FRAMES_W-1:0] r_att_hits, n_att_hits;
    logic                r_talk, n_talk;

    logic                r_out_valid;
    logic                r_out_talk;
    logic [LEVEL_W-1:0]  r_out_score;

    logic [MAG_W-1:0]    w_mag;
    logic [SUM_W:0]      w_sum_add;
    logic [SUM_W-1:0]    w_dividend;
    logic [DEN_W-1:0]    w_divisor;
    logic                w_div_busy;
    logic                w_div_done;
    logic [SUM_W-1:0]    w_quo;
    logic [SUM_W-1:0]    w_excess;
    logic                w_loud;
    logic                w_fast;
    logic [FRAMES_W-1:0] w_att_inc;
    logic [FRAMES_W-1:0] w_rel_inc;
    logic                w_out_take;

    assign w_mag     = i_sample[SAMPLE_W-1] ? (~{1'b1, i_sample} + MAG_W'(1))
                                            : {1'b0, i_sample};
    assign w_sum_add = {1'b0, r_sum} + (SUM_W + 1)'(w_mag);

    always_comb begin
        if (i_cmd.div_sel == DIV_SEL_SUM) begin
            w_dividend = r_sum;
            w_divisor  = (r_denom == '0) ? DEN_W'(1) : r_denom;
        end else begin
            w_dividend = SUM_W'(r_count);
            w_divisor  = (r_rate == '0) ? DEN_W'(1) : DEN_W'(r_rate);
        end
    end

    fevd_div #(
        .N_W (SUM_W),
        .D_W (DEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_loud    = w_quo > SUM_W'(r_level);
    assign w_excess  = w_quo - SUM_W'(r_level);
    assign w_fast    = w_excess >= SUM_W'(r_margin);
    assign w_att_inc = r_att_hits + FRAMES_W'(1);
    assign w_rel_inc = r_rel_hits + FRAMES_W'(1);

    always_comb begin
        n_rel_hits = r_rel_hits;
        n_att_hits = r_att_hits;
        n_talk     = r_talk;
        if (w_loud) begin
            if (r_rel_hits != '0) begin
                n_rel_hits = r_rel_hits - FRAMES_W'(1);
            end
            if (!w_fast) begin
                n_att_hits = w_att_inc;
            end
            if (w_fast || (w_att_inc >= r_att_frames)) begin
                n_rel_hits = '0;
                n_att_hits = '0;
                n_talk     = 1'b1;
            end
        end else begin
            if (r_att_hits != '0) begin
                n_att_hits = r_att_hits - FRAMES_W'(1);
            end
            if (r_talk) begin
                n_rel_hits = w_rel_inc;
                if (w_rel_inc >= r_rel_frames) begin
                    n_rel_hits = '0;
                    n_att_hits = '0;
                    n_talk     = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level      <= RST_ENERGY_LEVEL;
            r_margin     <= RST_FAST_ATTACK_MARGIN;
            r_rel_frames <= RST_RELEASE_FRAMES;
            r_att_frames <= RST_ATTACK_FRAMES;
            r_rate       <= RST_RATE_DIVISOR;
        end else if (cfg.valid) begin
            unique case (cfg.index)
                REG_ENERGY_LEVEL:       r_level      <= cfg.data;
                REG_FAST_ATTACK_MARGIN: r_margin     <= cfg.data;
                REG_RELEASE_FRAMES:     r_rel_frames <= cfg.data[FRAMES_W-1:0];
                REG_ATTACK_FRAMES:      r_att_frames <= cfg.data[FRAMES_W-1:0];
                REG_RATE_DIVISOR:       r_rate       <= cfg.data[RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_out_take = r_out_valid && out_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_count     <= '0;
            r_rel_hits  <= '0;
            r_att_hits  <= '0;
            r_talk      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.judge) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.acc && (r_count < CNT_W'(MAX_FRAME_SAMPLES))) begin
                r_sum   <= w_sum_add[SUM_W] ? SUM_MAX : w_sum_add[SUM_W-1:0];
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.judge) begin
                r_sum       <= '0;
                r_count     <= '0;
                r_rel_hits  <= n_rel_hits;
                r_att_hits  <= n_att_hits;
                r_talk      <= n_talk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.denom_load) begin
            r_denom <= w_quo[DEN_W-1:0];
        end
        if (i_cmd.judge) begin
            r_out_talk  <= n_talk;
            r_out_score <= (|w_quo[SUM_W-1:LEVEL_W]) ? SCORE_MAX : w_quo[LEVEL_W-1:0];
        end
    end

    assign cfg.ready          = 1'b1;
    assign out_ch.valid       = r_out_valid;
    assign out_ch.talking     = r_out_talk;
    assign out_ch.frame_score = r_out_score;

    assign o_sts.div_busy = w_div_busy;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || out_ch.ready;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_FRAME_SAMPLES))
        else $error("frame sample count past limit");

    a_judge_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.judge |=> (r_out_valid && r_count == '0 && r_sum == '0))
        else $error("frame close did not load result and clear accumulators");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !out_ch.ready) |=>
            (r_out_valid && $stable(r_out_talk) && $stable(r_out_score)))
        else $error("pending result changed while stalled");

endmodule

>>> rtl/fevd_ctrl.sv
module fevd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_frame_end,
    output logic              o_in_ready,
    input  fevd_pkg::t_dp_sts i_sts,
    output fevd_pkg::t_dp_cmd o_cmd
);
    import fevd_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CNT      = 3'd1;
    localparam logic [2:0] S_CNT_WAIT = 3'd2;
    localparam logic [2:0] S_SUM      = 3'd3;
    localparam logic [2:0] S_SUM_WAIT = 3'd4;
    localparam logic [2:0] S_JUDGE    = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.div_sel    = DIV_SEL_COUNT;
        o_in_ready       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.acc = 1'b1;
                    if (i_in_frame_end) begin
                        n_state = S_CNT;
                    end
                end
            end
            S_CNT: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_CNT_WAIT;
            end
            S_CNT_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.denom_load = 1'b1;
                    n_state          = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.div_sel   = DIV_SEL_SUM;
                o_cmd.div_start = 1'b1;
                n_state         = S_SUM_WAIT;
            end
            S_SUM_WAIT: begin
                o_cmd.div_sel = DIV_SEL_SUM;
                if (i_sts.div_done) begin
                    n_state = S_JUDGE;
                end
            end
            S_JUDGE: begin
                if (i_sts.out_free) begin
                    o_cmd.judge = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_start_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_sts.div_busy)
        else $error("divider started while busy");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_CNT_WAIT || r_state == S_SUM_WAIT))
        else $error("divider finished outside a wait state");

    a_judge_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.judge |-> (i_sts.out_free && !o_in_ready))
        else $error("frame result loaded over a pending result");

endmodule

>>> rtl/frame_energy_voice_detector_unit.sv
// Frame energy voice activity detector.
// i_in carries one channel-0 audio sample per beat, with frame_end set on the
// last sample of a frame. i_cfg writes one register per beat (index 0 level,
// 1 fast attack margin, 2 release frames, 3 attack frames, 4 rate divisor);
// it is always ready and is meant to be used only while the block is idle.
// o_out carries one beat per frame: the talking flag after that frame and the
// frame score saturated to 18 bits.
// A sample without frame_end is only accumulated. A frame_end sample starts two
// passes of a shared 26-step restoring divider (count by rate divisor, then
// sum by that quotient); i_in is ready again once the result is loaded, and
// the result appears on o_out in the same cycle.
// The result sits in an output register: while o_out stalls, i_in keeps
// taking samples of the next frame, and only the next frame close waits
// for that register to drain.
// Reset restores the register defaults, clears the accumulators, the hit
// counters and the talking flag, and drops any pending result.
module frame_energy_voice_detector_unit #(
    parameter int MAX_FRAME_SAMPLES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fevd_in_if.sink     i_in,
    fevd_cfg_if.sink    i_cfg,
    fevd_out_if.source  o_out
);
    import fevd_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    assign i_in.ready = w_in_ready;

    fevd_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .i_in_frame_end (i_in.frame_end),
        .o_in_ready     (w_in_ready),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd)
    );

    fevd_datapath #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_in.sample),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .cfg      (i_cfg),
        .out_ch   (o_out)
    );

endmodule
